### hdl/icp_pkg.sv
// Package: shared types, codes and decode helpers for the intcode step processor.
`timescale 1ns / 1ps

package icp_pkg;

  localparam int unsigned MemWordsDef = 65536;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_MOD,
    ST_DIGIT,
    ST_DECODE,
    ST_OPND,
    ST_IND,
    ST_EXEC,
    ST_MULA,
    ST_MULB,
    ST_MULC,
    ST_MULW,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StHalt  = 2'd1,
    StBadOp = 2'd2,
    StRange = 2'd3
  } status_e;

  localparam logic OpLoad = 1'b0;
  localparam logic OpStep = 1'b1;

  localparam logic [6:0] OcAdd  = 7'd1;
  localparam logic [6:0] OcMul  = 7'd2;
  localparam logic [6:0] OcIn   = 7'd3;
  localparam logic [6:0] OcOut  = 7'd4;
  localparam logic [6:0] OcJt   = 7'd5;
  localparam logic [6:0] OcJf   = 7'd6;
  localparam logic [6:0] OcLt   = 7'd7;
  localparam logic [6:0] OcEq   = 7'd8;
  localparam logic [6:0] OcRb   = 7'd9;
  localparam logic [6:0] OcHalt = 7'd99;

  localparam logic [3:0] ModePos = 4'd0;
  localparam logic [3:0] ModeImm = 4'd1;
  localparam logic [3:0] ModeRel = 4'd2;

  // instruction word is reduced mod 10^5: opcode plus three mode digits
  localparam logic [16:0] ModBase  = 17'd100000;
  localparam logic [17:0] ModRecip = 18'd171798;  // floor(2^34 / 10^5)
  localparam logic [16:0] Dec10k   = 17'd10000;
  localparam logic [16:0] Dec1k    = 17'd1000;
  localparam logic [16:0] Dec100   = 17'd100;

  // decimal digit of x by weight d, x < 10*d
  function automatic logic [3:0] dec_digit(input logic [16:0] x, input logic [16:0] d);
    logic [3:0] q;
    q = '0;
    for (int k = 1; k < 10; k++) begin
      if ({4'b0, x} >= 21'(k) * {4'b0, d}) q = 4'(k);
    end
    return q;
  endfunction

endpackage

### hdl/intcode_processor_step.sv
// Top level: intcode processor, one load or one instruction per input beat.
`timescale 1ns / 1ps
//
// channel | dir | beat content
// --------+-----+---------------------------------------------------------
// s_axis  | in  | tuser: op; tdata: load_address[15:0], load_word[79:16]
// m_axis  | out | tuser: status[1:0], has_output[2]; tdata: out_value
// cfg     | in  | cfg_data: input_value
//
// After reset a clearing pass zeroes every word of the memory, with s_axis held
// off; cfg writes are taken throughout.
// A load beat or a step while stopped goes from idle straight to the result stage.
// A step: fetch, decimal decode (one byte per cycle mod 10^5, then one digit
// per cycle), decode, each operand plus an indirect read if needed, exec,
// the multiply states MULA, MULB, MULC, MULW for mul, then result; the single memory port sets the pace.
// A result waiting on m_axis does not block the next beat until it is done.

module intcode_processor_step #(
  parameter int unsigned MEM_WORDS = icp_pkg::MemWordsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // load_address[15:0], load_word[79:16]
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // out_value
  output logic [2:0]  m_axis_tuser,   // status[1:0], has_output[2]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data        // input_value
);

  localparam int AW  = $clog2(MEM_WORDS);
  localparam int PCW = $clog2(MEM_WORDS + 1);
  localparam int RBW = AW + 1;
  localparam logic [63:0] MemLim  = 64'(MEM_WORDS);
  localparam logic [63:0] MemLim2 = 64'(2 * MEM_WORDS);

  // word memory, one port, registered read
  logic [63:0] mem [MEM_WORDS];
  logic        mem_we, mem_re;
  logic [63:0] mem_a, mem_wd, mem_rd_q;

  icp_pkg::state_e state_q, state_d;

  logic [AW-1:0]  clr_q;
  logic [PCW-1:0] pc_q;
  logic [RBW-1:0] rb_q;
  logic           stop_q;
  logic [63:0]    inval_q;
  logic [63:0]    w_q;
  logic [2:0]     cnt_q;
  logic [16:0]    r_q;
  logic [3:0]     m0_q, m1_q, m2_q;
  logic [6:0]     code_q;
  logic [1:0]     n_q, wr_q, k_q;
  logic [63:0]    v0_q, v1_q;
  logic [AW-1:0]  wadr_q;
  logic [63:0]    prod_q;
  logic [31:0]    crs_q;
  logic [2:0]     res_user_q;
  logic           m_valid_q;
  logic [2:0]     m_user_q;
  logic [63:0]    m_data_q;

  logic acc, slot_free;
  assign acc       = s_axis_tvalid && s_axis_tready;
  assign slot_free = !m_valid_q || m_axis_tready;

  // byte-serial reduction mod 10^5
  logic [24:0] mod_x, mod_r;
  logic [42:0] mod_pr;
  logic [7:0]  mod_qt;
  logic [16:0] mod_nx;
  always_comb begin
    mod_x  = {r_q, w_q[63:56]};
    mod_pr = 43'(mod_x) * 43'(icp_pkg::ModRecip);
    mod_qt = mod_pr[41:34];
    mod_r  = mod_x - 25'(mod_qt) * 25'(icp_pkg::ModBase);
    mod_nx = (mod_r >= 25'(icp_pkg::ModBase)) ? 17'(mod_r - 25'(icp_pkg::ModBase))
                                              : mod_r[16:0];
  end

  // one decimal digit a cycle
  logic [16:0] dig_w, dig_r;
  logic [3:0]  dig;
  always_comb begin
    unique case (cnt_q)
      3'd0:    dig_w = icp_pkg::Dec10k;
      3'd1:    dig_w = icp_pkg::Dec1k;
      default: dig_w = icp_pkg::Dec100;
    endcase
    dig   = icp_pkg::dec_digit(r_q, dig_w);
    dig_r = r_q - 17'(21'(dig) * 21'(dig_w));
  end

  // decode
  logic [1:0] dec_n, dec_wr;
  logic       dec_known, dec_badmode, dec_oor;
  always_comb begin
    dec_n = 2'd0; dec_wr = 2'd3; dec_known = 1'b1;
    case (code_q)
      icp_pkg::OcAdd, icp_pkg::OcMul, icp_pkg::OcLt, icp_pkg::OcEq: begin
        dec_n = 2'd3; dec_wr = 2'd2;
      end
      icp_pkg::OcIn: begin
        dec_n = 2'd1; dec_wr = 2'd0;
      end
      icp_pkg::OcOut, icp_pkg::OcRb: dec_n = 2'd1;
      icp_pkg::OcJt, icp_pkg::OcJf:  dec_n = 2'd2;
      default: dec_known = 1'b0;
    endcase
    dec_badmode = (dec_n >= 2'd1 && (m0_q > icp_pkg::ModeRel ||
                   (dec_wr == 2'd0 && m0_q == icp_pkg::ModeImm))) ||
                  (dec_n >= 2'd2 && m1_q > icp_pkg::ModeRel) ||
                  (dec_n == 2'd3 && (m2_q > icp_pkg::ModeRel || m2_q == icp_pkg::ModeImm));
    dec_oor = (64'(pc_q) + 64'(dec_n)) >= MemLim;
  end

  // operand address
  logic [3:0]  cur_m;
  logic [63:0] rb_x, cur_adr, nxt_a;
  logic        cur_imm, cur_oor, cur_wr, more;
  always_comb begin
    unique case (k_q)
      2'd0:    cur_m = m0_q;
      2'd1:    cur_m = m1_q;
      default: cur_m = m2_q;
    endcase
    rb_x    = {{(64 - RBW){rb_q[RBW-1]}}, rb_q};
    cur_adr = (cur_m == icp_pkg::ModeRel) ? rb_x + mem_rd_q : mem_rd_q;
    cur_imm = cur_m == icp_pkg::ModeImm;
    cur_oor = cur_adr >= MemLim;
    cur_wr  = k_q == wr_q;
    more    = (3'(k_q) + 3'd1) < 3'(n_q);
    nxt_a   = 64'(pc_q) + 64'(k_q) + 64'd2;
  end

  // execute
  logic        jmp_c, rb_bad;
  logic [63:0] nb, sum01;
  logic        lt01;
  always_comb begin
    jmp_c  = (v0_q != 64'd0) == (code_q == icp_pkg::OcJt);
    nb     = rb_x + v0_q;
    rb_bad = (nb + MemLim) >= MemLim2;
    sum01  = v0_q + v1_q;
    lt01   = $signed(v0_q) < $signed(v1_q);
  end

  // next state and result decision
  logic            fin, fin_ho;
  icp_pkg::status_e fin_st;
  always_comb begin
    state_d = state_q;
    fin     = 1'b0;
    fin_st  = icp_pkg::StOk;
    fin_ho  = 1'b0;
    unique case (state_q)
      icp_pkg::ST_CLEAR:
        if (clr_q == AW'(MEM_WORDS - 1)) state_d = icp_pkg::ST_IDLE;
      icp_pkg::ST_IDLE:
        if (acc) begin
          if (s_axis_tuser == icp_pkg::OpLoad) begin
            fin = 1'b1;
          end else if (stop_q) begin
            fin = 1'b1; fin_st = icp_pkg::StHalt;
          end else if (64'(pc_q) >= MemLim) begin
            fin = 1'b1; fin_st = icp_pkg::StRange;
          end else begin
            state_d = icp_pkg::ST_FETCH;
          end
        end
      icp_pkg::ST_FETCH:
        if (mem_rd_q[63]) begin
          fin = 1'b1; fin_st = icp_pkg::StBadOp;
        end else begin
          state_d = icp_pkg::ST_MOD;
        end
      icp_pkg::ST_MOD:
        if (cnt_q == 3'd7) state_d = icp_pkg::ST_DIGIT;
      icp_pkg::ST_DIGIT:
        if (cnt_q == 3'd2) state_d = icp_pkg::ST_DECODE;
      icp_pkg::ST_DECODE:
        priority if (code_q == icp_pkg::OcHalt) begin
          fin = 1'b1; fin_st = icp_pkg::StHalt;
        end else if (!dec_known || dec_badmode) begin
          fin = 1'b1; fin_st = icp_pkg::StBadOp;
        end else if (dec_oor) begin
          fin = 1'b1; fin_st = icp_pkg::StRange;
        end else begin
          state_d = icp_pkg::ST_OPND;
        end
      icp_pkg::ST_OPND:
        priority if (!cur_imm && cur_oor) begin
          fin = 1'b1; fin_st = icp_pkg::StRange;
        end else if (!cur_imm && !cur_wr) begin
          state_d = icp_pkg::ST_IND;
        end else if (more) begin
          state_d = icp_pkg::ST_OPND;
        end else begin
          state_d = icp_pkg::ST_EXEC;
        end
      icp_pkg::ST_IND:
        state_d = more ? icp_pkg::ST_OPND : icp_pkg::ST_EXEC;
      icp_pkg::ST_EXEC:
        if (code_q == icp_pkg::OcMul) begin
          state_d = icp_pkg::ST_MULA;
        end else begin
          fin = 1'b1;
          fin_ho = code_q == icp_pkg::OcOut;
          if ((code_q == icp_pkg::OcJt || code_q == icp_pkg::OcJf) && jmp_c &&
              v1_q >= MemLim) fin_st = icp_pkg::StRange;
          if (code_q == icp_pkg::OcRb && rb_bad) fin_st = icp_pkg::StRange;
        end
      icp_pkg::ST_MULA: state_d = icp_pkg::ST_MULB;
      icp_pkg::ST_MULB: state_d = icp_pkg::ST_MULC;
      icp_pkg::ST_MULC: state_d = icp_pkg::ST_MULW;
      icp_pkg::ST_MULW: fin = 1'b1;
      icp_pkg::ST_DONE:
        if (slot_free) state_d = icp_pkg::ST_IDLE;
      default: state_d = icp_pkg::ST_IDLE;
    endcase
    if (fin) state_d = icp_pkg::ST_DONE;
  end

  // memory port and handshakes
  always_comb begin
    s_axis_tready = state_q == icp_pkg::ST_IDLE;
    cfg_ready     = 1'b1;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_a  = '0;
    mem_wd = '0;
    unique case (state_q)
      icp_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_a  = 64'(clr_q);
      end
      icp_pkg::ST_IDLE: begin
        if (acc && s_axis_tuser == icp_pkg::OpLoad) begin
          mem_a  = 64'(s_axis_tdata[15:0]);
          mem_we = mem_a < MemLim;
          mem_wd = s_axis_tdata[79:16];
        end else begin
          mem_re = acc;
          mem_a  = 64'(pc_q);
        end
      end
      icp_pkg::ST_DECODE: begin
        mem_re = 1'b1;
        mem_a  = 64'(pc_q) + 64'd1;
      end
      icp_pkg::ST_OPND: begin
        if (!cur_imm && !cur_oor && !cur_wr) begin
          mem_re = 1'b1;
          mem_a  = cur_adr;
        end else begin
          mem_re = more;
          mem_a  = nxt_a;
        end
      end
      icp_pkg::ST_IND: begin
        mem_re = more;
        mem_a  = nxt_a;
      end
      icp_pkg::ST_EXEC: begin
        mem_a = 64'(wadr_q);
        unique case (code_q)
          icp_pkg::OcAdd: begin mem_we = 1'b1; mem_wd = sum01; end
          icp_pkg::OcIn:  begin mem_we = 1'b1; mem_wd = inval_q; end
          icp_pkg::OcLt:  begin mem_we = 1'b1; mem_wd = 64'(lt01); end
          icp_pkg::OcEq:  begin mem_we = 1'b1; mem_wd = 64'(v0_q == v1_q); end
          default: ;
        endcase
      end
      icp_pkg::ST_MULW: begin
        mem_we = 1'b1;
        mem_a  = 64'(wadr_q);
        mem_wd = prod_q + {crs_q, 32'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_a[AW-1:0]] <= mem_wd;
    if (mem_re) mem_rd_q <= mem[mem_a[AW-1:0]];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      icp_pkg::ST_FETCH: begin
        w_q <= mem_rd_q;
        r_q <= '0;
      end
      icp_pkg::ST_MOD: begin
        r_q <= mod_nx;
        w_q <= {w_q[55:0], 8'b0};
      end
      icp_pkg::ST_DIGIT: begin
        r_q <= dig_r;
        unique case (cnt_q)
          3'd0:    m2_q <= dig;
          3'd1:    m1_q <= dig;
          default: begin
            m0_q   <= dig;
            code_q <= dig_r[6:0];
          end
        endcase
      end
      icp_pkg::ST_DECODE: begin
        n_q  <= dec_n;
        wr_q <= dec_wr;
      end
      icp_pkg::ST_OPND: begin
        if (cur_imm) begin
          if (k_q == 2'd0) v0_q <= mem_rd_q;
          else             v1_q <= mem_rd_q;
        end
        if (cur_wr) wadr_q <= cur_adr[AW-1:0];
      end
      icp_pkg::ST_IND: begin
        if (k_q == 2'd0) v0_q <= mem_rd_q;
        else             v1_q <= mem_rd_q;
      end
      icp_pkg::ST_MULA: prod_q <= 64'(v0_q[31:0]) * 64'(v1_q[31:0]);
      icp_pkg::ST_MULB: crs_q  <= 32'(v0_q[31:0] * v1_q[63:32]);
      icp_pkg::ST_MULC: crs_q  <= crs_q + 32'(v0_q[63:32] * v1_q[31:0]);
      default: ;
    endcase
    if (state_q == icp_pkg::ST_DONE && slot_free) begin
      m_data_q <= res_user_q[2] ? v0_q : 64'd0;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= icp_pkg::ST_CLEAR;
      clr_q      <= '0;
      pc_q       <= '0;
      rb_q       <= '0;
      stop_q     <= 1'b0;
      inval_q    <= 64'd1;
      cnt_q      <= '0;
      k_q        <= '0;
      res_user_q <= '0;
      m_valid_q  <= 1'b0;
      m_user_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid) inval_q <= cfg_data;
      if (state_q == icp_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);

      unique case (state_q)
        icp_pkg::ST_FETCH:  cnt_q <= '0;
        icp_pkg::ST_MOD:    cnt_q <= cnt_q + 3'd1;
        icp_pkg::ST_DIGIT:  cnt_q <= (cnt_q == 3'd2) ? 3'd0 : cnt_q + 3'd1;
        default: ;
      endcase

      if (state_q == icp_pkg::ST_DECODE) k_q <= '0;
      if ((state_q == icp_pkg::ST_IND ||
           (state_q == icp_pkg::ST_OPND && state_d == icp_pkg::ST_OPND)) && more) begin
        k_q <= k_q + 2'd1;
      end

      if (state_q == icp_pkg::ST_EXEC && fin && fin_st == icp_pkg::StOk) begin
        if ((code_q == icp_pkg::OcJt || code_q == icp_pkg::OcJf) && jmp_c)
          pc_q <= v1_q[PCW-1:0];
        else
          pc_q <= pc_q + PCW'(n_q) + PCW'(1);
        if (code_q == icp_pkg::OcRb) rb_q <= nb[RBW-1:0];
      end
      if (state_q == icp_pkg::ST_MULW) pc_q <= pc_q + PCW'(n_q) + PCW'(1);

      // result held in res_user_q while DONE waits for the output register
      if (fin) begin
        res_user_q <= {fin_ho, fin_st};
        if (fin_st != icp_pkg::StOk) stop_q <= 1'b1;
      end

      if (state_q == icp_pkg::ST_DONE && slot_free) m_user_q <= res_user_q;

      if (state_q == icp_pkg::ST_DONE && slot_free) m_valid_q <= 1'b1;
      else if (m_axis_tready)                       m_valid_q <= 1'b0;
    end
  end

  // output register is only rewritten once the previous beat has left
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tdata  = m_data_q;

endmodule
